### sv/fsa_pkg.sv
// Shared types and constants for the fixed-time signal aspect block.
// Depends on nothing; every other file refers to it by scoped names.
package fsa_pkg;

  // Register index codes on the configuration port.
  localparam logic [2:0] REG_PLAN_ENABLED = 3'd0;
  localparam logic [2:0] REG_NUM_GROUPS   = 3'd1;
  localparam logic [2:0] REG_GREEN_MS     = 3'd2;
  localparam logic [2:0] REG_AMBER_MS     = 3'd3;
  localparam logic [2:0] REG_ALL_RED_MS   = 3'd4;
  localparam logic [2:0] REG_OFFSET_MS    = 3'd5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int CNT_W    = 4;   // num_groups register width
  localparam int PHASE_W  = 18;  // three 16-bit times summed
  localparam int CYCLE_W  = PHASE_W + CNT_W;
  localparam int MAG_W    = 33;  // magnitude of a 33-bit signed time
  localparam int RAWIN_W  = 10;  // red-amber window, at most 1000 ms
  localparam int OUTCYC_W = 21;

  localparam logic [15:0] MIN_GREEN_MS = 16'd1000;
  localparam logic [15:0] RED_AMBER_MS = 16'd1000;

  // A live cycle is at least two phases of at least 1000 ms, so it exceeds
  // 2^10 and a magnitude of at most 2^32 needs no more than 22 reduction steps.
  localparam int NUM_CELLS = 22;

  // Edges from an accepted request to the edge that samples its strobe.
  localparam int RESULT_DELAY = NUM_CELLS + 4;

  typedef enum logic [1:0] {
    ASPECT_RED       = 2'd0,
    ASPECT_RED_AMBER = 2'd1,
    ASPECT_GREEN     = 2'd2,
    ASPECT_AMBER     = 2'd3
  } aspect_t;

  typedef struct packed {
    logic [7:0]         group_index;
    logic signed [31:0] now_ms;
  } query_t;

  typedef struct packed {
    aspect_t               aspect;
    logic [OUTCYC_W-1:0]   cycle_ms;
  } result_t;

  // Derived plan values, refreshed every cycle from the registers.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [CYCLE_W-1:0] cycle;
    logic [15:0]        green;
    logic [16:0]        amber_end;
    logic [RAWIN_W-1:0] ra_win;
    logic               ra_on;
  } plan_t;

  // One request travelling down the reduction chain.
  typedef struct packed {
    logic             vld;
    logic             bypass;      // answer is green without any timing
    logic             zero_cycle;  // plan unsignalised, report zero cycle
    logic [CNT_W-1:0] group;
    logic             neg;
    logic [MAG_W-1:0] rem;
  } token_t;

endpackage

### sv/fsa_cell.sv
// One reduction cell: conditionally subtracts the cycle shifted by SHIFT.
// Depends on fsa_pkg for the token type and widths.
module fsa_cell #(
  parameter int SHIFT = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fsa_pkg::CYCLE_W-1:0] cycle,
  input  fsa_pkg::token_t             tok_in,
  output fsa_pkg::token_t             tok_out
);

  localparam int DW = fsa_pkg::CYCLE_W + SHIFT + 2;

  logic [DW-1:0] diff;
  logic          take;
  fsa_pkg::token_t tok_next;

  always_comb begin
    diff = DW'(tok_in.rem) - (DW'(cycle) << SHIFT);
    take = !diff[DW-1];
    tok_next = tok_in;
    if (take) begin
      tok_next.rem = fsa_pkg::MAG_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.bypass     <= tok_next.bypass;
    tok_out.zero_cycle <= tok_next.zero_cycle;
    tok_out.group      <= tok_next.group;
    tok_out.neg        <= tok_next.neg;
    tok_out.rem        <= tok_next.rem;
  end

endmodule

### sv/fsa_decode.sv
// Tail of the pipeline: sign fix, position in the group's phase, aspect.
// Depends on fsa_pkg for the token, plan and result types.
module fsa_decode (
  input  logic              clk,
  input  logic              rst,
  input  fsa_pkg::plan_t    plan,
  input  fsa_pkg::token_t   tok_in,
  output logic              done,
  output fsa_pkg::result_t  result
);

  typedef struct packed {
    logic                        vld;
    logic                        bypass;
    logic                        zero_cycle;
    logic [fsa_pkg::CYCLE_W-1:0] t;
    logic [fsa_pkg::CYCLE_W-1:0] start;
  } pos_t;

  typedef struct packed {
    logic                        vld;
    logic                        bypass;
    logic                        zero_cycle;
    logic [fsa_pkg::CYCLE_W-1:0] since;
  } since_t;

  pos_t   pos, pos_next;
  since_t snc, snc_next;
  logic   done_next;
  fsa_pkg::result_t result_next;

  logic [fsa_pkg::CYCLE_W-1:0] rem_lo;
  logic [fsa_pkg::CYCLE_W:0]   wrap_sum;
  logic [fsa_pkg::CYCLE_W-1:0] until_ms;

  // The remainder is below the cycle; a negative time folds it back.
  always_comb begin
    rem_lo = tok_in.rem[fsa_pkg::CYCLE_W-1:0];
    pos_next.vld        = tok_in.vld;
    pos_next.bypass     = tok_in.bypass;
    pos_next.zero_cycle = tok_in.zero_cycle;
    if (tok_in.neg && (rem_lo != '0)) begin
      pos_next.t = plan.cycle - rem_lo;
    end else begin
      pos_next.t = rem_lo;
    end
    pos_next.start = fsa_pkg::CYCLE_W'(plan.phase * tok_in.group);
  end

  always_comb begin
    snc_next.vld        = pos.vld;
    snc_next.bypass     = pos.bypass;
    snc_next.zero_cycle = pos.zero_cycle;
    wrap_sum = {1'b0, pos.t} + {1'b0, plan.cycle};
    if (pos.t >= pos.start) begin
      snc_next.since = pos.t - pos.start;
    end else begin
      snc_next.since = fsa_pkg::CYCLE_W'(wrap_sum - {1'b0, pos.start});
    end
  end

  always_comb begin
    until_ms  = plan.cycle - snc.since;
    done_next = snc.vld;
    result_next.cycle_ms = snc.zero_cycle ? '0 : plan.cycle[fsa_pkg::OUTCYC_W-1:0];
    if (snc.bypass) begin
      result_next.aspect = fsa_pkg::ASPECT_GREEN;
    end else if (snc.since < fsa_pkg::CYCLE_W'(plan.green)) begin
      result_next.aspect = fsa_pkg::ASPECT_GREEN;
    end else if (snc.since < fsa_pkg::CYCLE_W'(plan.amber_end)) begin
      result_next.aspect = fsa_pkg::ASPECT_AMBER;
    end else if (plan.ra_on && (until_ms <= fsa_pkg::CYCLE_W'(plan.ra_win))) begin
      result_next.aspect = fsa_pkg::ASPECT_RED_AMBER;
    end else begin
      result_next.aspect = fsa_pkg::ASPECT_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos.vld <= 1'b0;
      snc.vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      pos.vld <= pos_next.vld;
      snc.vld <= snc_next.vld;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos.bypass     <= pos_next.bypass;
    pos.zero_cycle <= pos_next.zero_cycle;
    pos.t          <= pos_next.t;
    pos.start      <= pos_next.start;
    snc.bypass     <= snc_next.bypass;
    snc.zero_cycle <= snc_next.zero_cycle;
    snc.since      <= snc_next.since;
    result         <= result_next;
  end

endmodule

### sv/fixed_time_signal_aspect.sv
// Top level of the fixed-time signal aspect query block.
// Depends on fsa_pkg, fsa_cell and fsa_decode.
//
//   channel  handshake             payload
//   query    start / busy          query.group_index, query.now_ms
//   result   done (one cycle)      result.aspect, result.cycle_ms
//   config   cfg_we                cfg_addr, cfg_wdata
//
// A request is taken at every clock edge where start is high and busy is low,
// so one query enters per cycle. Its result is driven with done high once the
// request has passed the entry register, the row of reduction cells and the
// decode's position, since and result registers; the row of reduction cells
// takes the time modulo the cycle one quotient bit per cell.
// Reset is synchronous; busy is high only while rst is high, and the chain empties then.
// The receiver cannot stall, so nothing ever holds the pipeline.
module fixed_time_signal_aspect #(
  parameter int MAX_GROUPS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  fsa_pkg::query_t                query,
  output logic                           done,
  output fsa_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [fsa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fsa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers, reset to the plan's power-up values.
  logic                      plan_enabled;
  logic [fsa_pkg::CNT_W-1:0] num_groups;
  logic [15:0]               green_ms;
  logic [15:0]               amber_ms;
  logic [15:0]               all_red_ms;
  logic [31:0]               offset_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_enabled <= 1'b0;
      num_groups   <= '0;
      green_ms     <= 16'd1000;
      amber_ms     <= '0;
      all_red_ms   <= '0;
      offset_ms    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fsa_pkg::REG_PLAN_ENABLED: plan_enabled <= cfg_wdata[0];
        fsa_pkg::REG_NUM_GROUPS:   num_groups   <= cfg_wdata[fsa_pkg::CNT_W-1:0];
        fsa_pkg::REG_GREEN_MS:     green_ms     <= cfg_wdata[15:0];
        fsa_pkg::REG_AMBER_MS:     amber_ms     <= cfg_wdata[15:0];
        fsa_pkg::REG_ALL_RED_MS:   all_red_ms   <= cfg_wdata[15:0];
        fsa_pkg::REG_OFFSET_MS:    offset_ms    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective group count: register value saturated at MAX_GROUPS.
  logic [fsa_pkg::CNT_W-1:0]   groups_eff;
  logic                        unsignalised;
  logic [15:0]                 green_eff;
  logic [fsa_pkg::PHASE_W-1:0] phase_c;
  fsa_pkg::plan_t              plan, plan_next;

  always_comb begin
    if (int'(num_groups) > MAX_GROUPS) begin
      groups_eff = fsa_pkg::CNT_W'(MAX_GROUPS);
    end else begin
      groups_eff = num_groups;
    end
    unsignalised = !plan_enabled || (groups_eff < fsa_pkg::CNT_W'(2));
    green_eff = (green_ms < fsa_pkg::MIN_GREEN_MS) ? fsa_pkg::MIN_GREEN_MS : green_ms;
    phase_c = fsa_pkg::PHASE_W'(green_eff) + fsa_pkg::PHASE_W'(amber_ms)
            + fsa_pkg::PHASE_W'(all_red_ms);
    plan_next.phase     = phase_c;
    plan_next.cycle     = fsa_pkg::CYCLE_W'(phase_c * groups_eff);
    plan_next.green     = green_eff;
    plan_next.amber_end = {1'b0, green_eff} + {1'b0, amber_ms};
    plan_next.ra_win    = (all_red_ms < fsa_pkg::RED_AMBER_MS)
                        ? all_red_ms[fsa_pkg::RAWIN_W-1:0]
                        : fsa_pkg::RED_AMBER_MS[fsa_pkg::RAWIN_W-1:0];
    plan_next.ra_on     = (all_red_ms != '0);
  end

  // The derived plan is registered from the configuration registers. The user must change
  // configuration only while the block is empty; the block itself does not enforce it. The first
  // cell reads the cycle in the cycle after a request is taken, so the lag is never visible.
  always_ff @(posedge clk) begin
    plan <= plan_next;
  end

  assign busy = rst;

  // Entry stage: exact 33-bit sum of time and offset, split into sign and
  // magnitude for the unsigned reduction chain.
  logic                        accept;
  logic [fsa_pkg::MAG_W-1:0]   sum;
  fsa_pkg::token_t             tok_entry;
  fsa_pkg::token_t             tok [fsa_pkg::NUM_CELLS+1];

  assign accept = start && !busy;

  always_comb begin
    sum = {query.now_ms[31], query.now_ms} + {offset_ms[31], offset_ms};
    tok_entry.vld        = accept;
    tok_entry.zero_cycle = unsignalised;
    tok_entry.bypass     = unsignalised
                         || (query.group_index >= {{(8 - fsa_pkg::CNT_W){1'b0}}, groups_eff});
    tok_entry.group      = query.group_index[fsa_pkg::CNT_W-1:0];
    tok_entry.neg        = sum[fsa_pkg::MAG_W-1];
    tok_entry.rem        = sum[fsa_pkg::MAG_W-1] ? (~sum + fsa_pkg::MAG_W'(1)) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].vld <= 1'b0;
    end else begin
      tok[0].vld <= tok_entry.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok[0].bypass     <= tok_entry.bypass;
    tok[0].zero_cycle <= tok_entry.zero_cycle;
    tok[0].group      <= tok_entry.group;
    tok[0].neg        <= tok_entry.neg;
    tok[0].rem        <= tok_entry.rem;
  end

  // Row of reduction cells, highest shift first; each cell removes one
  // multiple of the cycle at its bit weight and hands the rest along.
  for (genvar i = 0; i < fsa_pkg::NUM_CELLS; i++) begin : g_cell
    fsa_cell #(
      .SHIFT(fsa_pkg::NUM_CELLS - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cycle   (plan.cycle),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  fsa_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .plan   (plan),
    .tok_in (tok[fsa_pkg::NUM_CELLS]),
    .done   (done),
    .result (result)
  );

endmodule

### sv/fsa_checker.sv
// Port-level checks for the fixed-time signal aspect block, bound to its top.
// Depends on fsa_pkg for the latency and aspect codes.
module fsa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input fsa_pkg::result_t               result
);

  // Every accepted request produces a strobe after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(fsa_pkg::RESULT_DELAY) done)
    else $error("accepted request produced no result");

  // No strobe without a request accepted at the matching edge.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, fsa_pkg::RESULT_DELAY))
    else $error("result strobe without a matching request");

  // An unsignalised plan always reads green.
  a_zero_cycle_green: assert property (@(posedge clk) disable iff (rst)
    (done && (result.cycle_ms == '0)) |-> (result.aspect == fsa_pkg::ASPECT_GREEN))
    else $error("non-green aspect with zero cycle");

  // Results streaming back to back share one plan, so one cycle length.
  a_cycle_steady: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done)) |-> (result.cycle_ms == $past(result.cycle_ms)))
    else $error("cycle length changed between consecutive results");

endmodule

bind fixed_time_signal_aspect fsa_checker u_fsa_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .result   (result)
);
